// ===== rtl/core/zcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// zcbs_pkg
// Types, codes and reset tables shared by the zoned clock with button setting.
// ----------------------------------------------------------------------------
package zcbs_pkg;

    localparam int unsigned NUM_ZONES_DEF = 4;
    localparam int unsigned MAX_ZONES     = 16;

    // ASCII codes used by the display and the serial entry check
    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_Z     = 7'h5A;
    localparam logic [6:0] CHAR_U     = 7'h55;
    localparam logic [6:0] CHAR_T     = 7'h54;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_FIVE  = 8'h35;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [4:0] HOUR_LAST   = 5'd23;
    localparam logic [5:0] MINUTE_LAST = 6'd59;
    localparam logic [5:0] HOURS_DAY   = 6'd24;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_DIGIT  = 3'd1,
        PH_SERIAL = 3'd2,
        PH_RUN    = 3'd3,
        PH_ZONE   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_UP     = 3'd1,
        MODE_DOWN   = 3'd2,
        MODE_LEFT   = 3'd3,
        MODE_RIGHT  = 3'd4,
        MODE_SERIAL = 3'd5
    } mode_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] serial_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] cursor;
        logic [6:0] letter_first;
        logic [6:0] letter_second;
        logic [4:0] shown_hour;
        logic [5:0] shown_minute;
        logic [5:0] seconds_now;
        logic [7:0] echo_byte;
        logic       echo_valid;
        logic       entry_error;
    } out_word_t;

    // Reset letters of a zone; zones past the fourth read "AA"
    function automatic logic [6:0] zone_letter_init(input int unsigned idx,
                                                    input logic second);
        logic [6:0] ch;
        ch = CHAR_A;
        unique case ({idx[1:0], second})
            3'b000:  ch = 7'h4D; // M
            3'b001:  ch = 7'h41; // A
            3'b010:  ch = 7'h4D; // M
            3'b011:  ch = 7'h4F; // O
            3'b100:  ch = 7'h4B; // K
            3'b101:  ch = 7'h41; // A
            3'b110:  ch = 7'h43; // C
            3'b111:  ch = 7'h45; // E
            default: ch = CHAR_A;
        endcase
        if (idx >= 4)
        begin
            ch = CHAR_A;
        end
        return ch;
    endfunction

    function automatic logic [4:0] zone_offset_init(input int unsigned idx);
        logic [4:0] off;
        off = 5'd0;
        unique case (idx[1:0])
            2'd0:    off = 5'd11;
            2'd1:    off = 5'd3;
            2'd2:    off = 5'd2;
            2'd3:    off = 5'd1;
            default: off = 5'd0;
        endcase
        if (idx >= 4)
        begin
            off = 5'd0;
        end
        return off;
    endfunction

    // Two BCD digits to a binary value
    function automatic logic [7:0] bcd_pair(input logic [3:0] tens, input logic [3:0] units);
        return {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, units};
    endfunction

endpackage

// ===== rtl/core/zoned_clock_with_button_setting.sv =====
// ----------------------------------------------------------------------------
// zoned_clock_with_button_setting
// Zoned digital clock set by buttons or by four serial digits.
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake            word
//   ----------   ---   ------------------   ---------------------------------
//   in_*         in    in_valid / in_stall  event code and serial byte
//   out_*        out   out_valid/out_stall  phase, cursor, display, echo, error
//
// Every accepted word yields exactly one result word, by way of the input
// register and then the result register. A new word can be taken every
// cycle while in_stall is low; the whole state update is one pass of short
// logic between the two registers. in_stall rises only while both registers
// hold words and out_stall is high. Reset loads the control state, the time,
// the zone table and the handshake registers at once; there is no clearing pass.
//
module zoned_clock_with_button_setting #(
    parameter int unsigned NUM_ZONES = zcbs_pkg::NUM_ZONES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  zcbs_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output zcbs_pkg::out_word_t out_word
);
    import zcbs_pkg::*;

    localparam int unsigned ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam logic [ZW-1:0] ZONE_LAST = ZW'(NUM_ZONES - 1);

    // ------------------------------------------------------------------
    // Handshake and input register
    // ------------------------------------------------------------------
    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t out_word_next;
    logic      adv;

    // The word in the input register moves on when the result slot is free
    // or is being taken in this cycle.
    assign adv      = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_word_reg <= in_word;
        end
        if (adv)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // ------------------------------------------------------------------
    // Clock state
    // ------------------------------------------------------------------
    phase_t      phase_reg,        phase_next;
    logic [1:0]  cursor_reg,       cursor_next;
    logic [3:0]  digit_reg [4];
    logic [3:0]  digit_next [4];
    logic [4:0]  hour_reg,         hour_next;
    logic [5:0]  minute_reg,       minute_next;
    logic [5:0]  second_reg,       second_next;
    logic [ZW-1:0] zone_sel_reg,   zone_sel_next;
    logic [1:0]  serial_count_reg, serial_count_next;

    // Zone table: one read port at the next selection, one write port
    logic [6:0]  letter_first_reg  [NUM_ZONES];
    logic [6:0]  letter_second_reg [NUM_ZONES];
    logic [4:0]  offset_reg        [NUM_ZONES];
    logic [6:0]  rd_first, rd_second, ed_first, ed_second;
    logic [4:0]  rd_offset, ed_offset;
    logic        zone_we;

    // Only the first three serial characters are stored; the fourth is
    // checked straight from the input register.
    logic [7:0]  serial_buf_reg [3];
    logic        buf_we;

    // Tick: advance hh:mm:ss from the current registers
    logic [5:0]  tick_sec, tick_min;
    logic [4:0]  tick_hour;

    always_comb
    begin
        tick_sec  = second_reg + 6'd1;
        tick_min  = minute_reg;
        tick_hour = hour_reg;
        if (second_reg >= MINUTE_LAST)
        begin
            tick_sec = 6'd0;
            tick_min = minute_reg + 6'd1;
            if (minute_reg >= MINUTE_LAST)
            begin
                tick_min  = 6'd0;
                tick_hour = hour_reg + 5'd1;
                if (hour_reg >= HOUR_LAST)
                begin
                    tick_hour = 5'd0;
                end
            end
        end
    end

    // Zone selection first, so the table read sees the new zone
    always_comb
    begin
        zone_sel_next = zone_sel_reg;
        if (adv && phase_reg == PH_RUN)
        begin
            if (in_word_reg.mode == MODE_UP)
            begin
                zone_sel_next = (zone_sel_reg == ZONE_LAST) ? '0 : zone_sel_reg + 1'b1;
            end
            else if (in_word_reg.mode == MODE_DOWN)
            begin
                zone_sel_next = (zone_sel_reg == '0) ? ZONE_LAST : zone_sel_reg - 1'b1;
            end
        end
    end

    assign rd_first  = letter_first_reg[zone_sel_next];
    assign rd_second = letter_second_reg[zone_sel_next];
    assign rd_offset = offset_reg[zone_sel_next];

    // Digit edit: the edited digits converted to a time
    logic [7:0] dt_hour_raw, dt_min_raw;
    logic [4:0] dt_hour;
    logic [5:0] dt_min;

    // Serial entry: check of the four characters
    logic [7:0] sr_hour_raw, sr_min_raw;
    logic       sr_ok;

    always_comb
    begin
        dt_hour_raw = bcd_pair(digit_next[0], digit_next[1]);
        dt_min_raw  = bcd_pair(digit_next[2], digit_next[3]);
        // edited hours stay below 48, so one subtract does the mod 24
        dt_hour = (dt_hour_raw >= {2'b00, HOURS_DAY}) ?
                  5'(dt_hour_raw - {2'b00, HOURS_DAY}) : 5'(dt_hour_raw);
        dt_min  = dt_min_raw[5:0];
    end

    always_comb
    begin
        sr_hour_raw = bcd_pair(serial_buf_reg[0][3:0], serial_buf_reg[1][3:0]);
        sr_min_raw  = bcd_pair(serial_buf_reg[2][3:0], in_word_reg.serial_byte[3:0]);
        sr_ok = (serial_buf_reg[0] >= CHAR_ZERO) && (serial_buf_reg[0] <= CHAR_TWO)
             && (serial_buf_reg[1] >= CHAR_ZERO) && (serial_buf_reg[1] <= CHAR_NINE)
             && (serial_buf_reg[2] >= CHAR_ZERO) && (serial_buf_reg[2] <= CHAR_FIVE)
             && (in_word_reg.serial_byte >= CHAR_ZERO)
             && (in_word_reg.serial_byte <= CHAR_NINE)
             && (sr_hour_raw <= {3'b000, HOUR_LAST});
    end

    // Main state update
    logic        echo_ok, entry_err;
    logic [5:0]  hour_sum;
    logic [4:0]  hour_shown;

    always_comb
    begin
        phase_next        = phase_reg;
        cursor_next       = cursor_reg;
        digit_next        = digit_reg;
        hour_next         = hour_reg;
        minute_next       = minute_reg;
        second_next       = second_reg;
        serial_count_next = serial_count_reg;
        ed_first          = rd_first;
        ed_second         = rd_second;
        ed_offset         = rd_offset;
        zone_we           = 1'b0;
        buf_we            = 1'b0;
        echo_ok           = 1'b0;
        entry_err         = 1'b0;

        if (adv)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (in_word_reg.mode == MODE_LEFT)
                    begin
                        phase_next  = PH_DIGIT;
                        cursor_next = 2'd0;
                    end
                    else if (in_word_reg.mode == MODE_RIGHT)
                    begin
                        phase_next        = PH_SERIAL;
                        serial_count_next = 2'd0;
                    end
                end
                PH_DIGIT:
                begin
                    if (in_word_reg.mode == MODE_UP)
                    begin
                        unique case (cursor_reg)
                            2'd0:
                            begin
                                digit_next[0] = (digit_reg[0] >= 4'd2) ? 4'd0 : digit_reg[0] + 4'd1;
                                // hour tens of 2 or 0 after a wrap: fold units above 3
                                if ((digit_next[0] == 4'd2 || digit_next[0] == 4'd0)
                                    && digit_reg[1] > 4'd3)
                                begin
                                    digit_next[1] = 4'd0;
                                end
                            end
                            2'd1:
                            begin
                                if (digit_reg[0] == 4'd2)
                                begin
                                    digit_next[1] = (digit_reg[1] >= 4'd3) ? 4'd0
                                                                           : digit_reg[1] + 4'd1;
                                end
                                else
                                begin
                                    digit_next[1] = (digit_reg[1] >= 4'd9) ? 4'd0
                                                                           : digit_reg[1] + 4'd1;
                                end
                            end
                            2'd2:
                                digit_next[2] = (digit_reg[2] >= 4'd5) ? 4'd0 : digit_reg[2] + 4'd1;
                            default:
                                digit_next[3] = (digit_reg[3] >= 4'd9) ? 4'd0 : digit_reg[3] + 4'd1;
                        endcase
                        hour_next   = dt_hour;
                        minute_next = dt_min;
                    end
                    else if (in_word_reg.mode == MODE_DOWN)
                    begin
                        unique case (cursor_reg)
                            2'd0:
                            begin
                                if (digit_reg[0] == 4'd0)
                                begin
                                    digit_next[0] = 4'd2;
                                    if (digit_reg[1] > 4'd3)
                                    begin
                                        digit_next[1] = 4'd3;
                                    end
                                end
                                else
                                begin
                                    digit_next[0] = digit_reg[0] - 4'd1;
                                end
                            end
                            2'd1:
                            begin
                                if (digit_reg[1] == 4'd0)
                                begin
                                    digit_next[1] = (digit_reg[0] == 4'd2) ? 4'd3 : 4'd9;
                                end
                                else
                                begin
                                    digit_next[1] = digit_reg[1] - 4'd1;
                                end
                            end
                            2'd2:
                                digit_next[2] = (digit_reg[2] == 4'd0) ? 4'd5 : digit_reg[2] - 4'd1;
                            default:
                                digit_next[3] = (digit_reg[3] == 4'd0) ? 4'd9 : digit_reg[3] - 4'd1;
                        endcase
                        hour_next   = dt_hour;
                        minute_next = dt_min;
                    end
                    else if (in_word_reg.mode == MODE_LEFT)
                    begin
                        if (cursor_reg != 2'd0)
                        begin
                            cursor_next = cursor_reg - 2'd1;
                        end
                    end
                    else if (in_word_reg.mode == MODE_RIGHT)
                    begin
                        if (cursor_reg == 2'd3)
                        begin
                            hour_next   = dt_hour;
                            minute_next = dt_min;
                            phase_next  = PH_RUN;
                            cursor_next = 2'd0;
                        end
                        else
                        begin
                            cursor_next = cursor_reg + 2'd1;
                        end
                    end
                end
                PH_SERIAL:
                begin
                    if (in_word_reg.mode == MODE_SERIAL)
                    begin
                        echo_ok = 1'b1;
                        if (serial_count_reg == 2'd3)
                        begin
                            serial_count_next = 2'd0;
                            if (sr_ok)
                            begin
                                hour_next   = sr_hour_raw[4:0];
                                minute_next = sr_min_raw[5:0];
                                phase_next  = PH_RUN;
                                cursor_next = 2'd0;
                            end
                            else
                            begin
                                entry_err = 1'b1;
                            end
                        end
                        else
                        begin
                            buf_we            = 1'b1;
                            serial_count_next = serial_count_reg + 2'd1;
                        end
                    end
                end
                PH_RUN:
                begin
                    if (in_word_reg.mode == MODE_TICK)
                    begin
                        second_next = tick_sec;
                        minute_next = tick_min;
                        hour_next   = tick_hour;
                    end
                    else if (in_word_reg.mode == MODE_RIGHT)
                    begin
                        phase_next  = PH_ZONE;
                        cursor_next = 2'd0;
                    end
                end
                default:
                begin
                    // zone edit
                    if (in_word_reg.mode == MODE_TICK)
                    begin
                        second_next = tick_sec;
                        minute_next = tick_min;
                        hour_next   = tick_hour;
                    end
                    else if (in_word_reg.mode == MODE_UP)
                    begin
                        zone_we = 1'b1;
                        unique case (cursor_reg)
                            2'd0:    ed_first  = (rd_first >= CHAR_Z) ? CHAR_A : rd_first + 7'd1;
                            2'd1:    ed_second = (rd_second >= CHAR_Z) ? CHAR_A : rd_second + 7'd1;
                            2'd2:    ed_offset = (rd_offset >= HOUR_LAST) ? 5'd0 : rd_offset + 5'd1;
                            default: zone_we   = 1'b0;
                        endcase
                    end
                    else if (in_word_reg.mode == MODE_DOWN)
                    begin
                        zone_we = 1'b1;
                        unique case (cursor_reg)
                            2'd0:    ed_first  = (rd_first <= CHAR_A) ? CHAR_Z : rd_first - 7'd1;
                            2'd1:    ed_second = (rd_second <= CHAR_A) ? CHAR_Z : rd_second - 7'd1;
                            2'd2:    ed_offset = (rd_offset == 5'd0) ? HOUR_LAST : rd_offset - 5'd1;
                            default: zone_we   = 1'b0;
                        endcase
                    end
                    else if (in_word_reg.mode == MODE_LEFT)
                    begin
                        if (cursor_reg != 2'd0)
                        begin
                            cursor_next = cursor_reg - 2'd1;
                        end
                    end
                    else if (in_word_reg.mode == MODE_RIGHT)
                    begin
                        if (cursor_reg == 2'd2)
                        begin
                            phase_next  = PH_RUN;
                            cursor_next = 2'd0;
                        end
                        else
                        begin
                            cursor_next = cursor_reg + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

    // Result word from the updated state
    always_comb
    begin
        hour_sum   = {1'b0, hour_next} + {1'b0, ed_offset};
        hour_shown = (hour_sum >= HOURS_DAY) ? 5'(hour_sum - HOURS_DAY) : hour_sum[4:0];

        out_word_next.phase  = phase_next;
        out_word_next.cursor = (phase_next == PH_SERIAL) ? {1'b0, serial_count_next}
                                                         : {1'b0, cursor_next};
        if (phase_next == PH_RUN || phase_next == PH_ZONE)
        begin
            out_word_next.letter_first  = ed_first;
            out_word_next.letter_second = ed_second;
            out_word_next.shown_hour    = hour_shown;
        end
        else
        begin
            out_word_next.letter_first  = CHAR_U;
            out_word_next.letter_second = CHAR_T;
            out_word_next.shown_hour    = hour_next;
        end
        out_word_next.shown_minute = minute_next;
        out_word_next.seconds_now  = second_next;
        out_word_next.echo_byte    = echo_ok ? in_word_reg.serial_byte : 8'd0;
        out_word_next.echo_valid   = echo_ok;
        out_word_next.entry_error  = entry_err;
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_START;
            cursor_reg       <= 2'd0;
            digit_reg        <= '{default: 4'd0};
            hour_reg         <= 5'd0;
            minute_reg       <= 6'd0;
            second_reg       <= 6'd0;
            zone_sel_reg     <= '0;
            serial_count_reg <= 2'd0;
            for (int unsigned i = 0; i < NUM_ZONES; i++)
            begin
                letter_first_reg[ZW'(i)]  <= zone_letter_init(i, 1'b0);
                letter_second_reg[ZW'(i)] <= zone_letter_init(i, 1'b1);
                offset_reg[ZW'(i)]        <= zone_offset_init(i);
            end
        end
        else
        begin
            phase_reg        <= phase_next;
            cursor_reg       <= cursor_next;
            digit_reg        <= digit_next;
            hour_reg         <= hour_next;
            minute_reg       <= minute_next;
            second_reg       <= second_next;
            zone_sel_reg     <= zone_sel_next;
            serial_count_reg <= serial_count_next;
            if (zone_we)
            begin
                letter_first_reg[zone_sel_reg]  <= ed_first;
                letter_second_reg[zone_sel_reg] <= ed_second;
                offset_reg[zone_sel_reg]        <= ed_offset;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            serial_buf_reg[serial_count_reg] <= in_word_reg.serial_byte;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hold_without_word: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(phase_reg) && $stable(hour_reg) && $stable(second_reg))
        else $error("clock state changed with no word moving on");

    a_zone_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        zone_sel_reg <= ZONE_LAST)
        else $error("zone selection out of range");

    a_error_on_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.entry_error |->
            out_word_reg.echo_valid && out_word_reg.phase == PH_SERIAL
            && out_word_reg.cursor == 3'd0)
        else $error("entry error outside the end of a serial round");

    a_echo_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_word_reg.echo_valid |-> out_word_reg.echo_byte == 8'd0)
        else $error("echo byte set without an echo");

    a_result_follows_word: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_valid_reg)
        else $error("advanced word produced no result");

endmodule

// ===== sim/zoned_clock_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zoned_clock_checker
// Watches both channels of the zoned clock, predicts the display word for
// every accepted input word and compares the result words in order.
// ----------------------------------------------------------------------------
module zoned_clock_checker #(
    parameter int unsigned NUM_ZONES = zcbs_pkg::NUM_ZONES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  zcbs_pkg::in_word_t  in_word,
    input  logic                out_valid,
    input  logic                out_stall,
    input  zcbs_pkg::out_word_t out_word,
    output int                  fail_count,
    output int                  pending
);

    import zcbs_pkg::*;

    // Zone names M A, M O, K A, C E and their hour offsets, first zone first
    localparam logic [55:0] HOME_LETTERS = {7'h4D, 7'h41, 7'h4D, 7'h4F,
                                            7'h4B, 7'h41, 7'h43, 7'h45};
    localparam logic [19:0] HOME_OFFSETS = {5'd11, 5'd3, 5'd2, 5'd1};

    // Index widths of the zone tables
    localparam int unsigned ZONE_IW   = $clog2(MAX_ZONES);
    localparam int unsigned LETTER_IW = $clog2(2 * MAX_ZONES);

    phase_t      phase_q;
    logic [2:0]  cursor_q;
    int unsigned digit_q [4];
    logic [4:0]  hour_q;
    logic [5:0]  minute_q;
    logic [5:0]  second_q;
    int unsigned zone_q;
    logic [6:0]  letter_q [2*MAX_ZONES];
    logic [4:0]  offset_q [MAX_ZONES];
    logic [7:0]  entry_q [4];
    logic [2:0]  entry_count_q;

    out_word_t   due_displays [$];
    out_word_t   next_display;
    out_word_t   want;

    function automatic bit is_between(input logic [7:0] ch, input logic [7:0] lo,
                                      input logic [7:0] hi);
        return ch >= lo && ch <= hi;
    endfunction

    task automatic load_edit_time();
        hour_q   = 5'((digit_q[0] * 10 + digit_q[1]) % 24);
        minute_q = 6'((digit_q[2] * 10 + digit_q[3]) % 64);
    endtask

    task automatic count_second();
        second_q++;
        if (second_q >= 60)
        begin
            second_q = '0;
            minute_q++;
            if (minute_q >= 60)
            begin
                minute_q = '0;
                hour_q++;
                if (hour_q >= 24)
                begin
                    hour_q = '0;
                end
            end
        end
    endtask

    task automatic step_clock(input in_word_t w, output out_word_t r);
        int unsigned z;
        int unsigned c;
        int unsigned idx;
        int          entry_hour;
        int          entry_minute;
        r = '0;
        z = zone_q % NUM_ZONES % MAX_ZONES;
        case (phase_q)
            PH_START:
            begin
                if (w.mode == MODE_LEFT)
                begin
                    phase_q  = PH_DIGIT;
                    cursor_q = '0;
                end
                else if (w.mode == MODE_RIGHT)
                begin
                    phase_q       = PH_SERIAL;
                    entry_count_q = '0;
                end
            end
            PH_DIGIT:
            begin
                c = (cursor_q > 3) ? 3 : int'(cursor_q);
                if (w.mode == MODE_UP || w.mode == MODE_DOWN)
                begin
                    case (c)
                        0:
                        begin
                            if (w.mode == MODE_UP)
                            begin
                                digit_q[0] = (digit_q[0] + 1) % 3;
                                if ((digit_q[0] == 2 || digit_q[0] == 0) && digit_q[1] > 3)
                                begin
                                    digit_q[1] = 0;
                                end
                            end
                            else if (digit_q[0] == 0)
                            begin
                                digit_q[0] = 2;
                                if (digit_q[1] > 3)
                                begin
                                    digit_q[1] = 3;
                                end
                            end
                            else
                            begin
                                digit_q[0]--;
                            end
                        end
                        1:
                        begin
                            if (w.mode == MODE_UP)
                            begin
                                digit_q[1]++;
                                if (digit_q[1] >= ((digit_q[0] == 2) ? 4 : 10))
                                begin
                                    digit_q[1] = 0;
                                end
                            end
                            else if (digit_q[1] == 0)
                            begin
                                digit_q[1] = (digit_q[0] == 2) ? 3 : 9;
                            end
                            else
                            begin
                                digit_q[1]--;
                            end
                        end
                        2:
                        begin
                            if (w.mode == MODE_UP)
                            begin
                                digit_q[2] = (digit_q[2] + 1) % 6;
                            end
                            else
                            begin
                                digit_q[2] = (digit_q[2] == 0) ? 5 : digit_q[2] - 1;
                            end
                        end
                        default:
                        begin
                            if (w.mode == MODE_UP)
                            begin
                                digit_q[3] = (digit_q[3] + 1) % 10;
                            end
                            else
                            begin
                                digit_q[3] = (digit_q[3] == 0) ? 9 : digit_q[3] - 1;
                            end
                        end
                    endcase
                    load_edit_time();
                end
                else if (w.mode == MODE_LEFT)
                begin
                    if (cursor_q != 0)
                    begin
                        cursor_q--;
                    end
                end
                else if (w.mode == MODE_RIGHT)
                begin
                    cursor_q++;
                    if (cursor_q >= 4)
                    begin
                        load_edit_time();
                        phase_q  = PH_RUN;
                        cursor_q = '0;
                    end
                end
            end
            PH_SERIAL:
            begin
                if (w.mode == MODE_SERIAL)
                begin
                    entry_q[entry_count_q[1:0]] = w.serial_byte;
                    r.echo_byte  = w.serial_byte;
                    r.echo_valid = 1'b1;
                    entry_count_q++;
                    if (entry_count_q >= 4)
                    begin
                        entry_count_q = '0;
                        entry_hour   = (int'(entry_q[0]) - int'(CHAR_ZERO)) * 10
                                     + (int'(entry_q[1]) - int'(CHAR_ZERO));
                        entry_minute = (int'(entry_q[2]) - int'(CHAR_ZERO)) * 10
                                     + (int'(entry_q[3]) - int'(CHAR_ZERO));
                        if (is_between(entry_q[0], CHAR_ZERO, CHAR_TWO)
                            && is_between(entry_q[1], CHAR_ZERO, CHAR_NINE)
                            && is_between(entry_q[2], CHAR_ZERO, CHAR_FIVE)
                            && is_between(entry_q[3], CHAR_ZERO, CHAR_NINE)
                            && entry_hour <= 23)
                        begin
                            hour_q   = 5'(entry_hour);
                            minute_q = 6'(entry_minute);
                            phase_q  = PH_RUN;
                            cursor_q = '0;
                        end
                        else
                        begin
                            r.entry_error = 1'b1;
                        end
                    end
                end
            end
            PH_RUN:
            begin
                if (w.mode == MODE_TICK)
                begin
                    count_second();
                end
                else if (w.mode == MODE_UP)
                begin
                    zone_q = (z + 1) % NUM_ZONES;
                end
                else if (w.mode == MODE_DOWN)
                begin
                    zone_q = (z == 0) ? NUM_ZONES - 1 : z - 1;
                end
                else if (w.mode == MODE_RIGHT)
                begin
                    phase_q  = PH_ZONE;
                    cursor_q = '0;
                end
            end
            default:
            begin
                if (w.mode == MODE_TICK)
                begin
                    count_second();
                end
                else if (w.mode == MODE_UP || w.mode == MODE_DOWN)
                begin
                    if (cursor_q < 2)
                    begin
                        idx = 2 * z + int'(cursor_q);
                        if (w.mode == MODE_UP)
                        begin
                            letter_q[LETTER_IW'(idx)] =
                                (letter_q[LETTER_IW'(idx)] >= CHAR_Z) ? CHAR_A
                                : letter_q[LETTER_IW'(idx)] + 7'd1;
                        end
                        else
                        begin
                            letter_q[LETTER_IW'(idx)] =
                                (letter_q[LETTER_IW'(idx)] <= CHAR_A) ? CHAR_Z
                                : letter_q[LETTER_IW'(idx)] - 7'd1;
                        end
                    end
                    else if (cursor_q == 2)
                    begin
                        if (w.mode == MODE_UP)
                        begin
                            offset_q[ZONE_IW'(z)] = 5'((int'(offset_q[ZONE_IW'(z)]) + 1) % 24);
                        end
                        else
                        begin
                            offset_q[ZONE_IW'(z)] = (offset_q[ZONE_IW'(z)] == 0) ? 5'd23
                                                    : offset_q[ZONE_IW'(z)] - 5'd1;
                        end
                    end
                end
                else if (w.mode == MODE_LEFT)
                begin
                    if (cursor_q != 0)
                    begin
                        cursor_q--;
                    end
                end
                else if (w.mode == MODE_RIGHT)
                begin
                    cursor_q++;
                    if (cursor_q >= 3)
                    begin
                        phase_q  = PH_RUN;
                        cursor_q = '0;
                    end
                end
            end
        endcase

        z = zone_q % NUM_ZONES % MAX_ZONES;
        r.phase  = phase_q;
        r.cursor = (phase_q == PH_SERIAL) ? entry_count_q : cursor_q;
        if (phase_q == PH_RUN || phase_q == PH_ZONE)
        begin
            r.letter_first  = letter_q[LETTER_IW'(2*z)];
            r.letter_second = letter_q[LETTER_IW'(2*z + 1)];
            r.shown_hour    = 5'((int'(hour_q) + int'(offset_q[ZONE_IW'(z)])) % 24);
        end
        else
        begin
            r.letter_first  = CHAR_U;
            r.letter_second = CHAR_T;
            r.shown_hour    = hour_q;
        end
        r.shown_minute = minute_q;
        r.seconds_now  = second_q;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_q       = PH_START;
            cursor_q      = '0;
            digit_q       = '{0, 0, 0, 0};
            hour_q        = '0;
            minute_q      = '0;
            second_q      = '0;
            zone_q        = 0;
            entry_q       = '{8'h00, 8'h00, 8'h00, 8'h00};
            entry_count_q = '0;
            for (int i = 0; i < MAX_ZONES; i++)
            begin
                if (i < 4)
                begin
                    letter_q[LETTER_IW'(2*i)]     = HOME_LETTERS[(7 - 2*i)*7 +: 7];
                    letter_q[LETTER_IW'(2*i + 1)] = HOME_LETTERS[(6 - 2*i)*7 +: 7];
                    offset_q[ZONE_IW'(i)]         = HOME_OFFSETS[(3 - i)*5 +: 5];
                end
                else
                begin
                    letter_q[LETTER_IW'(2*i)]     = CHAR_A;
                    letter_q[LETTER_IW'(2*i + 1)] = CHAR_A;
                    offset_q[ZONE_IW'(i)]         = '0;
                end
            end
            due_displays.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                step_clock(in_word, next_display);
                due_displays.push_back(next_display);
            end
            if (out_valid && !out_stall)
            begin
                if (due_displays.size() == 0)
                begin
                    $error("result word %h arrived with no word pending", out_word);
                    fail_count++;
                end
                else
                begin
                    want = due_displays.pop_front();
                    check_field("phase", 8'(want.phase), 8'(out_word.phase));
                    check_field("cursor", 8'(want.cursor), 8'(out_word.cursor));
                    check_field("letter_first", 8'(want.letter_first),
                                8'(out_word.letter_first));
                    check_field("letter_second", 8'(want.letter_second),
                                8'(out_word.letter_second));
                    check_field("shown_hour", 8'(want.shown_hour), 8'(out_word.shown_hour));
                    check_field("shown_minute", 8'(want.shown_minute),
                                8'(out_word.shown_minute));
                    check_field("seconds_now", 8'(want.seconds_now), 8'(out_word.seconds_now));
                    check_field("echo_byte", want.echo_byte, out_word.echo_byte);
                    check_field("echo_valid", 8'(want.echo_valid), 8'(out_word.echo_valid));
                    check_field("entry_error", 8'(want.entry_error),
                                8'(out_word.entry_error));
                end
            end
        end
        pending = due_displays.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives button, tick and serial events into the zoned clock and judges the
// run; the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

    import zcbs_pkg::*;

    // Event codes the block has no meaning for; it must show its state unchanged
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS   = 1850;
    // last stretch of the random part runs with no gaps and no stalls
    localparam int QUIET_WORDS    = 250;
    // cycles with no word moving on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 1000;
    // results pass through the input and result registers; leave room to drain
    localparam int DRAIN_CYCLES   = 16;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_word_t  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_word;

    int        fail_count;
    int        pending;
    int        words_sent   = 0;
    int        quiet_cycles = 0;
    bit        gaps_on      = 1'b0;
    bit        stalls_on    = 1'b0;

    zoned_clock_with_button_setting dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    zoned_clock_checker display_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one word at the falling edge, optionally after a short gap, and
    // hold it until the block takes it. Returns just after a falling edge with
    // valid still high so back-to-back words stay back-to-back.
    task automatic send_word(input logic [2:0] mode, input logic [7:0] serial_byte);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{mode: mode, serial_byte: serial_byte};
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
        words_sent++;
    endtask

    // Four serial characters, as typed on the terminal
    task automatic send_entry(input string chars);
        for (int k = 0; k < 4; k++)
        begin
            send_word(MODE_SERIAL, chars[k]);
        end
    endtask

    // Result side: stall in random bursts while allowed
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int         base;
        int         kind;
        logic [2:0] step;

        // Hold reset, then release it on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        // The start phase is left once for good, so each run takes one of the
        // two setting paths; the seed picks which.
        if ($urandom_range(0, 1) == 0)
        begin
            // Start phase: ticks, unused buttons, stray bytes and spare codes drop
            send_word(MODE_TICK, rnd_byte());
            send_word(MODE_DOWN, rnd_byte());
            send_word(MODE_SERIAL, rnd_byte());
            send_word(MODE_SPARE_LO, rnd_byte());
            send_word(MODE_LEFT, rnd_byte());
            // Digit edit: a tick is ignored, LEFT at the first digit stays put
            send_word(MODE_TICK, rnd_byte());
            send_word(MODE_LEFT, rnd_byte());
            // Hour units to 9, then DOWN on hour tens wraps to 2 and clamps units to 3
            send_word(MODE_RIGHT, rnd_byte());
            send_word(MODE_DOWN, rnd_byte());
            send_word(MODE_LEFT, rnd_byte());
            send_word(MODE_DOWN, rnd_byte());
            // UP on hour tens wraps to 0, then steps to 1
            send_word(MODE_UP, rnd_byte());
            send_word(MODE_UP, rnd_byte());
            // Hour units to 4, then hour tens reaching 2 clears the units
            send_word(MODE_RIGHT, rnd_byte());
            send_word(MODE_UP, rnd_byte());
            send_word(MODE_LEFT, rnd_byte());
            send_word(MODE_UP, rnd_byte());
            // Hour units with tens at 2 wrap within 0..3 both ways
            send_word(MODE_RIGHT, rnd_byte());
            send_word(MODE_DOWN, rnd_byte());
            send_word(MODE_UP, rnd_byte());
            send_word(MODE_DOWN, rnd_byte());
            // Minute tens wrap within 0..5
            send_word(MODE_RIGHT, rnd_byte());
            send_word(MODE_DOWN, rnd_byte());
            send_word(MODE_UP, rnd_byte());
            send_word(MODE_DOWN, rnd_byte());
            // Minute units wrap to 9; stepping past the last digit takes 23:59
            send_word(MODE_RIGHT, rnd_byte());
            send_word(MODE_DOWN, rnd_byte());
            send_word(MODE_RIGHT, rnd_byte());
        end
        else
        begin
            send_word(MODE_TICK, rnd_byte());
            send_word(MODE_UP, rnd_byte());
            send_word(MODE_SPARE_HI, rnd_byte());
            send_word(MODE_SERIAL, rnd_byte());
            send_word(MODE_RIGHT, rnd_byte());
            // Serial entry: buttons and ticks are ignored
            send_word(MODE_LEFT, rnd_byte());
            send_word(MODE_TICK, rnd_byte());
            // Hour above 23, hour tens above 2, minute tens above 5, then
            // characters just outside the digits; each one flags an error
            send_entry("2400");
            send_entry("3059");
            send_entry("1960");
            send_entry("0:/9");
            send_entry("2359");
        end

        // Random part: the clock runs; ticks in runs long enough to carry,
        // zone stepping, zone edit sessions, and some noise and broken sessions
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS)
        begin
            if (words_sent - base > RANDOM_WORDS - QUIET_WORDS)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            else
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                repeat ($urandom_range(1, 90)) send_word(MODE_TICK, rnd_byte());
            end
            else if (kind <= 5)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_word(($urandom_range(0, 1) == 1) ? MODE_UP : MODE_DOWN, rnd_byte());
                end
            end
            else if (kind <= 7)
            begin
                // Full zone edit: both letters and the offset, then back to run
                send_word(MODE_RIGHT, rnd_byte());
                for (int field = 0; field < 3; field++)
                begin
                    step = ($urandom_range(0, 1) == 1) ? MODE_UP : MODE_DOWN;
                    repeat ($urandom_range(0, 30))
                    begin
                        send_word(($urandom_range(0, 7) == 0) ? MODE_TICK : step, rnd_byte());
                    end
                    if ($urandom_range(0, 5) == 0)
                    begin
                        send_word(MODE_LEFT, rnd_byte());
                        send_word(MODE_RIGHT, rnd_byte());
                    end
                    send_word(MODE_RIGHT, rnd_byte());
                end
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    send_word(3'($urandom_range(0, 7)), rnd_byte());
                end
            end
            else
            begin
                // Broken session: open the editor and wander without closing it
                send_word(MODE_RIGHT, rnd_byte());
                repeat ($urandom_range(1, 8))
                begin
                    send_word(3'($urandom_range(MODE_UP, MODE_LEFT)), rnd_byte());
                end
            end
        end

        // Drop valid, let every result drain, then give the verdict
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
